FILE: design/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, transaction types and accumulator lane commands.
// ----------------------------------------------------------------------------
package modexp_pkg;

	// Width of base, exponent, modulus and result
	localparam int OPERAND_BITS = 31;

	// Width of the multiplier bit counter (counts OPERAND_BITS-1 down to 0)
	localparam int CNT_W = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;

	// Request transaction
	typedef struct packed {
		logic [OPERAND_BITS-1:0] base;
		logic [OPERAND_BITS-1:0] exponent;
		logic [OPERAND_BITS-1:0] modulus;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic [OPERAND_BITS-1:0] power_mod;
		logic                    bad_modulus;
	} rsp_t;

	// Command to one shift-and-add accumulator lane
	typedef enum logic [1:0] {
		LOP_HOLD,
		LOP_CLEAR,
		LOP_DBL,
		LOP_ADD
	} lane_op_t;

endpackage

FILE: design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square-and-multiply over bit-serial modular multipliers.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                  | Payload          | Direction
//  --------+----------------------------+------------------+----------
//  request | req_valid / req_stall      | req (req_t)      | in
//  response| rsp_valid / rsp_stall      | rsp (rsp_t)      | out
//
//  Zero modulus or zero exponent: the request goes straight to the
//  response load. Otherwise the base is first reduced over
//  OPERAND_BITS multiplier bits, and each exponent bit takes one square
//  and one multiply run side by side in two lanes, double and add on
//  alternate cycles over OPERAND_BITS multiplier bits, plus one commit
//  state.
//  One transaction in flight; a finished response waits in the output
//  register while the next request is accepted.
//  arst_n clears control state only; no clearing pass is needed.
//
module modular_exponentiation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  modexp_pkg::req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output modexp_pkg::rsp_t  rsp
);
	import modexp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_LOAD,
		ST_MUL,
		ST_STEP,
		ST_DONE
	} state_t;

	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(OPERAND_BITS - 1);
	localparam logic [OPERAND_BITS-1:0] ONE = OPERAND_BITS'(1);

	state_t                  state_q;
	logic                    phase_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [OPERAND_BITS-1:0] e_q;
	logic [OPERAND_BITS-1:0] m_q;
	logic [OPERAND_BITS-1:0] r_q;
	logic [OPERAND_BITS-1:0] sq_q;
	logic [OPERAND_BITS-1:0] y_q;
	logic [OPERAND_BITS-1:0] res_q;
	logic                    bad_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    accept;
	logic                    ybit;
	logic                    last_bit;
	logic [OPERAND_BITS-1:0] e_shift;
	logic [OPERAND_BITS-1:0] r_new;
	lane_op_t                op_r;
	lane_op_t                op_s;
	logic [OPERAND_BITS-1:0] x_s;
	logic [OPERAND_BITS-1:0] acc_r;
	logic [OPERAND_BITS-1:0] acc_s;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign ybit      = y_q[OPERAND_BITS-1];
	assign last_bit  = phase_q && (cnt_q == '0);
	assign e_shift   = e_q >> 1;
	assign r_new     = e_q[0] ? acc_r : r_q;

	// Drive lane commands: clear on accept and between runs, double on phase 0, add on phase 1 when the bit is set
	always_comb begin
		op_r = LOP_HOLD;
		op_s = LOP_HOLD;
		x_s  = sq_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_s = LOP_CLEAR;
				end
			end
			ST_REDUCE: begin
				x_s  = ONE;
				op_s = !phase_q ? LOP_DBL : (ybit ? LOP_ADD : LOP_HOLD);
			end
			ST_LOAD, ST_STEP: begin
				op_r = LOP_CLEAR;
				op_s = LOP_CLEAR;
			end
			ST_MUL: begin
				op_r = !phase_q ? LOP_DBL : (ybit ? LOP_ADD : LOP_HOLD);
				op_s = op_r;
			end
			default: begin
				op_r = LOP_HOLD;
				op_s = LOP_HOLD;
			end
		endcase
	end

	// Lane R multiplies the running result by the square; lane S first reduces the base, then squares
	modexp_lane u_lane_r (
		.clk (clk),
		.op  (op_r),
		.x   (r_q),
		.m   (m_q),
		.acc (acc_r)
	);

	modexp_lane u_lane_s (
		.clk (clk),
		.op  (op_s),
		.x   (x_s),
		.m   (m_q),
		.acc (acc_s)
	);

	// Sequence the transaction and hold the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Drop a taken response; ST_DONE reloads the register on its own
			if (rsp_valid_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						m_q     <= req.modulus;
						e_q     <= req.exponent;
						y_q     <= req.base;
						r_q     <= (req.modulus == ONE) ? '0 : ONE;
						phase_q <= 1'b0;
						cnt_q   <= CNT_TOP;
						if (req.modulus == '0) begin
							res_q   <= '0;
							bad_q   <= 1'b1;
							state_q <= ST_DONE;
						end else if (req.exponent == '0) begin
							res_q   <= ONE;
							bad_q   <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							bad_q   <= 1'b0;
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE, ST_MUL: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						y_q   <= {y_q[OPERAND_BITS-2:0], 1'b0};
						cnt_q <= cnt_q - 1'b1;
					end
					if (last_bit) begin
						state_q <= (state_q == ST_REDUCE) ? ST_LOAD : ST_STEP;
					end
				end
				ST_LOAD: begin
					sq_q    <= acc_s;
					y_q     <= acc_s;
					phase_q <= 1'b0;
					cnt_q   <= CNT_TOP;
					state_q <= ST_MUL;
				end
				ST_STEP: begin
					r_q     <= r_new;
					sq_q    <= acc_s;
					y_q     <= acc_s;
					e_q     <= e_shift;
					phase_q <= 1'b0;
					cnt_q   <= CNT_TOP;
					if (e_shift == '0) begin
						res_q   <= r_new;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.power_mod   <= res_q;
						rsp_q.bad_modulus <= bad_q;
						rsp_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// Running result and square stay reduced during the multiply loop
	a_r_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (r_q < m_q))
		else $error("running result not below modulus");

	a_sq_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (sq_q < m_q))
		else $error("square not below modulus");

	// Accumulators never leave the residue range while working
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> ((acc_r < m_q) && (acc_s < m_q)))
		else $error("lane accumulator not below modulus");

	// A zero modulus skips all arithmetic
	a_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.modulus == '0)) |=> (state_q == ST_DONE) && bad_q)
		else $error("zero modulus not flagged");

	// A flagged response carries zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.bad_modulus) |-> (rsp.power_mod == '0))
		else $error("flagged response is nonzero");
`endif

endmodule

FILE: design/modexp_lane.sv
// ----------------------------------------------------------------------------
// Modular exponentiation accumulator lane
// One bit-serial modular multiplier accumulator: holds, clears, doubles modulo m,
// or adds an operand modulo m, one step per cycle unless held.
// ----------------------------------------------------------------------------
module modexp_lane (
	input  logic                                 clk,
	input  modexp_pkg::lane_op_t                 op,
	input  logic [modexp_pkg::OPERAND_BITS-1:0]  x,
	input  logic [modexp_pkg::OPERAND_BITS-1:0]  m,
	output logic [modexp_pkg::OPERAND_BITS-1:0]  acc
);
	import modexp_pkg::*;

	logic [OPERAND_BITS-1:0] acc_q;
	logic [OPERAND_BITS-1:0] addend;
	logic [OPERAND_BITS:0]   sum;
	logic [OPERAND_BITS:0]   diff;
	logic [OPERAND_BITS-1:0] acc_next;

	// Add either the accumulator itself (double) or the operand, then reduce once
	always_comb begin
		addend   = (op == LOP_DBL) ? acc_q : x;
		sum      = {1'b0, acc_q} + {1'b0, addend};
		diff     = sum - {1'b0, m};
		acc_next = (sum >= {1'b0, m}) ? diff[OPERAND_BITS-1:0] : sum[OPERAND_BITS-1:0];
	end

	// Hold, clear or advance the accumulator
	always_ff @(posedge clk) begin
		case (op)
			LOP_CLEAR: acc_q <= '0;
			LOP_DBL,
			LOP_ADD:   acc_q <= acc_next;
			default:   acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule
